[rtl/wtad_pkg.sv]
package wtad_pkg;

	localparam int BIN_W   = 16;
	localparam int DEC_N   = 5;
	localparam int BCD_W   = DEC_N * 4;
	localparam int CNT_W   = $clog2(BIN_W);
	localparam int IDX_W   = $clog2(DEC_N);

	localparam logic [7:0]       ASCII_ZERO    = 8'h30;
	localparam logic [7:0]       ASCII_UPPER_A = 8'h41;
	localparam logic [BIN_W-1:0] WIDE_LIMIT    = 16'h00FF;

	localparam logic FUNC_DEC = 1'b0;
	localparam logic FUNC_HEX = 1'b1;

	localparam logic [IDX_W-1:0] HEX_TOP_WIDE   = 3'd3;
	localparam logic [IDX_W-1:0] HEX_TOP_NARROW = 3'd1;

	typedef struct packed {
		logic             func;
		logic [BIN_W-1:0] value;
	} wtad_in_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} wtad_out_t;

	// converter control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} wtad_dab_ctl_t;

	// one character request from the sequencer
	typedef struct packed {
		logic             fire;
		logic             last;
		logic [IDX_W-1:0] idx;
	} wtad_emit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} wtad_state_t;

	// nibble to uppercase ascii digit
	function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
		logic [7:0] code;
		if (nib > 4'd9) begin
			code = ASCII_UPPER_A + {4'd0, nib} - 8'd10;
		end else begin
			code = ASCII_ZERO + {4'd0, nib};
		end
		return code;
	endfunction

endpackage

[rtl/wtad_dabble.sv]
module wtad_dabble (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtad_pkg::wtad_dab_ctl_t       ctl,
	input  logic [wtad_pkg::BIN_W-1:0]    value,
	output logic [wtad_pkg::BCD_W-1:0]    bcd
);
	import wtad_pkg::*;

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < DEC_N; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// one shift-add-3 step per cycle while ctl.step is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (ctl.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	assign bcd = bcd_q;

endmodule

[rtl/wtad_seq.sv]
module wtad_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic                          func,
	input  logic                          wide,
	input  logic [wtad_pkg::BCD_W-1:0]    bcd,
	output wtad_pkg::wtad_dab_ctl_t       ctl,
	output wtad_pkg::wtad_emit_t          emit,
	output logic                          busy
);
	import wtad_pkg::*;

	wtad_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] lead;

	// most significant nonzero decimal digit, zero if none
	always_comb begin
		lead = '0;
		for (int i = 0; i < DEC_N; i++) begin
			if (bcd[i*4 +: 4] != 4'd0) begin
				lead = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		ctl       = '0;
		emit.fire = 1'b0;
		emit.last = (idx_q == '0);
		emit.idx  = idx_q;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (go) begin
					ctl.load = 1'b1;
					cnt_d    = '0;
					state_d  = (func == FUNC_HEX) ? ST_FIND : ST_CONV;
				end
			end
			ST_CONV: begin
				ctl.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BIN_W - 1)) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (func == FUNC_HEX) begin
					idx_d = wide ? HEX_TOP_WIDE : HEX_TOP_NARROW;
				end else begin
					idx_d = lead;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit.fire = 1'b1;
				if (idx_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/word_to_ascii_digits.sv]
// channel   ports                      transfer when
// input     start, busy, item          start high and busy low at a rising edge
// output    strobe, result             strobe high, one cycle per character
//
// decimal: busy for 16 shift-add-3 steps of the converter,
// one leading-digit scan and n characters, n = 1..5
// hex: busy for the select state and n characters, n = 2 or 4; each character
// appears on result the cycle after its sequencer slot, from an output register
// arst_n clears the sequencer and the strobe; the receiver cannot stall
module word_to_ascii_digits (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  wtad_pkg::wtad_in_t    item,
	output logic                  strobe,
	output wtad_pkg::wtad_out_t   result
);
	import wtad_pkg::*;

	logic          go;
	wtad_in_t      item_q;
	wtad_dab_ctl_t ctl;
	wtad_emit_t    emit;
	logic [BCD_W-1:0] bcd;
	logic [BCD_W-1:0] src;
	logic          strobe_q;
	wtad_out_t     result_q;

	assign go = start && !busy;

	// capture the item on transfer
	always_ff @(posedge clk) begin
		if (go) begin
			item_q <= item;
		end
	end

	wtad_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.value  (item.value),
		.bcd    (bcd)
	);

	// format comes straight from the port in the transfer cycle
	wtad_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.func   (go ? item.func : item_q.func),
		.wide   (item_q.value > WIDE_LIMIT),
		.bcd    (bcd),
		.ctl    (ctl),
		.emit   (emit),
		.busy   (busy)
	);

	// digit source: bcd digits or raw nibbles
	assign src = (item_q.func == FUNC_HEX) ? {{(BCD_W-BIN_W){1'b0}}, item_q.value} : bcd;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.fire) begin
			result_q.char_code <= nib_to_ascii(src[emit.idx*4 +: 4]);
			result_q.last      <= emit.last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// a transfer makes the block busy
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	// the final character is never followed directly by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("character right after last");

	// a character seen while idle closes its number
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !busy |-> result.last)
		else $error("idle character without last");

	// only digit codes are produced
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.char_code >= 8'h30 && result.char_code <= 8'h39) ||
			(result.char_code >= 8'h41 && result.char_code <= 8'h46)))
		else $error("bad character code");

endmodule

[verif/word_to_ascii_digits_tb.sv]
`timescale 1ns / 100ps

module word_to_ascii_digits_tb;
	import wtad_pkg::*;

	localparam int STALL_LIMIT = 400;
	localparam int TAIL_CYCLES = 30;
	localparam int PHASE_WORDS = 80;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	logic      busy;
	wtad_in_t  item   = '0;
	logic      strobe;
	wtad_out_t result;

	int stall_cycles = 0;

	// digits expected from the block, oldest first
	class digit_scoreboard;
		wtad_out_t chars_due[$];
		int        errors = 0;

		// note an accepted word and queue the characters it must produce
		function void note_word(wtad_in_t w);
			logic [3:0] dec_digit[DEC_N];
			logic [3:0] nib;
			wtad_out_t  ch;
			int         rest;
			int         top;
			int         n_hex;
			if (w.func == FUNC_DEC) begin
				rest = int'(w.value);
				for (int i = 0; i < DEC_N; i++) begin
					dec_digit[i] = 4'(rest % 10);
					rest = rest / 10;
				end
				// most significant nonzero digit, a lone zero otherwise
				top = 0;
				for (int i = DEC_N - 1; i > 0; i--) begin
					if (dec_digit[i] != 4'd0 && top == 0)
						top = i;
				end
				for (int i = top; i >= 0; i--) begin
					ch.char_code = ASCII_ZERO + {4'd0, dec_digit[i]};
					ch.last      = (i == 0);
					chars_due.push_back(ch);
				end
			end else begin
				n_hex = (w.value > WIDE_LIMIT) ? 4 : 2;
				for (int i = n_hex - 1; i >= 0; i--) begin
					nib = w.value[i*4 +: 4];
					ch.char_code = (nib > 4'd9) ? ASCII_UPPER_A + {4'd0, nib} - 8'd10
						: ASCII_ZERO + {4'd0, nib};
					ch.last = (i == 0);
					chars_due.push_back(ch);
				end
			end
		endfunction

		// compare one character transfer with the oldest expectation
		function void check_char(wtad_out_t got);
			wtad_out_t want;
			if (chars_due.size() == 0) begin
				$display("%0t: unexpected char_code %h last %b", $time,
					got.char_code, got.last);
				errors++;
				return;
			end
			want = chars_due.pop_front();
			if (got.char_code !== want.char_code) begin
				$display("%0t: char_code expected %h actual %h", $time,
					want.char_code, got.char_code);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return chars_due.size();
		endfunction
	endclass

	digit_scoreboard digits_sb = new();

	word_to_ascii_digits dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// every character transfer is checked
	always @(posedge clk) begin
		if (arst_n && strobe)
			digits_sb.check_char(result);
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("word_to_ascii_digits regression: fail");
			$finish;
		end
	end

	// offer one word, idling first with the given percentage, and wait for the transfer
	task automatic send_word(input logic fmt, input logic [BIN_W-1:0] word,
		input int idle_pct);
		wtad_in_t w;
		w.func  = fmt;
		w.value = word;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		digits_sb.note_word(w);
	endtask

	// hold off until every queued character has come out
	task automatic drain_chars();
		start <= 1'b0;
		do @(posedge clk); while (digits_sb.pending() != 0);
	endtask

	// random word, biased toward digit-count and hex-width boundaries
	function automatic logic [BIN_W-1:0] pick_word();
		logic [BIN_W-1:0] edges[12] = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100,
			16'd255, 16'd256, 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd65535};
		case ($urandom_range(4))
			0: return edges[$urandom_range(11)];
			1: return BIN_W'($urandom_range(255));
			2: return BIN_W'($urandom_range(99));
			default: return BIN_W'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		int idle_pct[3];
		idle_pct = '{38, 88, 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: decimal digit counts and inner zeros
		send_word(FUNC_DEC, 16'd0, 0);
		send_word(FUNC_DEC, 16'd9, 0);
		send_word(FUNC_DEC, 16'd10, 0);
		send_word(FUNC_DEC, 16'd99, 0);
		send_word(FUNC_DEC, 16'd100, 0);
		send_word(FUNC_DEC, 16'd1000, 0);
		send_word(FUNC_DEC, 16'd9999, 0);
		send_word(FUNC_DEC, 16'd10000, 0);
		send_word(FUNC_DEC, 16'd10203, 0);
		send_word(FUNC_DEC, 16'd32768, 0);
		send_word(FUNC_DEC, 16'd65535, 0);
		// directed: hex widths, zeros within width, every letter
		send_word(FUNC_HEX, 16'h0000, 0);
		send_word(FUNC_HEX, 16'h000A, 0);
		send_word(FUNC_HEX, 16'h00FF, 0);
		send_word(FUNC_HEX, 16'h0100, 0);
		send_word(FUNC_HEX, 16'h0F00, 0);
		send_word(FUNC_HEX, 16'hABCD, 0);
		send_word(FUNC_HEX, 16'h1EF2, 0);
		send_word(FUNC_HEX, 16'h5A5A, 0);
		send_word(FUNC_HEX, 16'hFFFF, 0);
		drain_chars();

		// random phases: moderate idling, heavy idling, back to back
		for (int ph = 0; ph < 3; ph++) begin
			for (int k = 0; k < PHASE_WORDS; k++) begin
				send_word(logic'($urandom_range(1)), pick_word(), idle_pct[ph]);
				if (k == PHASE_WORDS / 2)
					drain_chars();
			end
		end

		// let the last characters out, then a quiet tail
		start <= 1'b0;
		while (digits_sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (digits_sb.errors == 0)
			$display("word_to_ascii_digits regression: pass");
		else
			$display("word_to_ascii_digits regression: fail");
		$finish;
	end

endmodule
